>>> hw/rtl/imsu_pkg.sv
// ----------------------------------------------------------------------------
// Ising Metropolis spin update: shared package
// Sizes, field positions, operation codes and register addresses shared by
// the spin update block and its checker.
// ----------------------------------------------------------------------------
package imsu_pkg;

   localparam int MAX_WIDTH   = 64;
   localparam int MAX_SITES   = 4096;
   localparam int RANDOM_BITS = 16;

   localparam int SITE_W   = $clog2(MAX_SITES);
   localparam int COUNT_W  = SITE_W + 1;
   localparam int WIDTH_W  = $clog2(MAX_WIDTH) + 1;
   localparam int THRESH_W = RANDOM_BITS + 1;
   localparam int DE_W     = 5;
   localparam int MAG_W    = $clog2(MAX_SITES) + 2;

   // Request data: site, random fraction, fill spin, zero padded to bytes.
   localparam int REQ_RND_LSB   = SITE_W;
   localparam int REQ_FILL_BIT  = SITE_W + RANDOM_BITS;
   localparam int REQ_TDATA_W   = ((SITE_W + RANDOM_BITS + 1 + 7) / 8) * 8;

   // Response data: flipped, new spin, energy change, magnetization.
   localparam int RSP_FLIP_BIT  = 0;
   localparam int RSP_SPIN_BIT  = 1;
   localparam int RSP_DE_LSB    = 2;
   localparam int RSP_MAG_LSB   = RSP_DE_LSB + DE_W;
   localparam int RSP_TDATA_W   = ((RSP_MAG_LSB + MAG_W + 7) / 8) * 8;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic OP_STEP = 1'b0;
   localparam logic OP_FILL = 1'b1;

   localparam logic [CSR_ADDR_W-1:0] ADDR_LATTICE_WIDTH = 4'h0;
   localparam logic [CSR_ADDR_W-1:0] ADDR_THRESH_FOUR   = 4'h4;
   localparam logic [CSR_ADDR_W-1:0] ADDR_THRESH_EIGHT  = 4'h8;

endpackage

>>> hw/rtl/imsu_ram.sv
// ----------------------------------------------------------------------------
// Generic single-clock RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module imsu_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/ising_metropolis_spin_update.sv
// ----------------------------------------------------------------------------
// Ising Metropolis spin update
// Square spin lattice with helical boundaries, one bit per site in a RAM,
// with Metropolis single-spin steps, whole-lattice fill and magnetization.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on the req channel (tuser = operation) and each one yields
//   exactly one item on the rsp channel (tuser = site error flag).
//   A step reads the site and its four neighbors from the spin RAM, one
//   read per cycle through its single read port, then decides and writes
//   back. An out-of-range site is answered at the accepting edge itself,
//   so such items can follow back to back while the result register is
//   free. A fill writes one site per cycle.
//   Writing lattice_width starts a recount of the magnetization, one site
//   per cycle, during which no item is taken.
//   After reset the block writes +1 into all 4096 sites, one per cycle, and
//   takes no item until that is done; registers may be written meanwhile.
//   The result sits in an output register, so a new item is accepted while
//   the receiver stalls; a finished result then waits until that register
//   frees up. One item is worked on at a time.
// ----------------------------------------------------------------------------
module ising_metropolis_spin_update
   import imsu_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // req_tdata: site, random_fraction, fill_spin, zero padding
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // req_tuser: operation
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // rsp_tdata: flipped, new_spin, energy_change, magnetization, zero padding
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // rsp_tuser: site_error
   output logic                   rsp_tuser,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_RECOUNT,
      ST_IDLE,
      ST_READ,
      ST_DECIDE,
      ST_FILL,
      ST_DONE
   } state_type;

   localparam logic signed [MAG_W-1:0] MAG_ONE = MAG_W'(1);
   localparam logic signed [MAG_W-1:0] MAG_TWO = MAG_W'(2);

   state_type                 state_ff, state_in;
   logic [COUNT_W-1:0]        sweep_ff, sweep_in;
   logic                      rc_valid_ff, rc_valid_in;
   logic                      recount_pend_ff, recount_pend_in;
   logic [WIDTH_W-1:0]        width_ff, width_in;
   logic [THRESH_W-1:0]       thresh4_ff, thresh4_in;
   logic [THRESH_W-1:0]       thresh8_ff, thresh8_in;
   logic [WIDTH_W-1:0]        used_w_ff, used_w_in;
   logic [COUNT_W-1:0]        used_n_ff, used_n_in;
   logic signed [MAG_W-1:0]   mag_ff, mag_in;
   logic [SITE_W-1:0]         site_ff, site_in;
   logic [RANDOM_BITS-1:0]    rnd_ff, rnd_in;
   logic                      fill_spin_ff, fill_spin_in;
   logic [2:0]                phase_ff, phase_in;
   logic                      spin_ff, spin_in;
   logic [2:0]                ones_ff, ones_in;
   logic                      res_err_ff, res_err_in;
   logic                      res_flip_ff, res_flip_in;
   logic                      res_spin_ff, res_spin_in;
   logic [DE_W-1:0]           res_de_ff, res_de_in;
   logic                      rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_TDATA_W-1:0]    rsp_tdata_ff, rsp_tdata_in;
   logic                      rsp_tuser_ff, rsp_tuser_in;

   logic                      width_wr;
   logic                      csr_wr;
   logic [WIDTH_W-1:0]        w_raw;
   logic [WIDTH_W-1:0]        w_sat;
   logic [2*WIDTH_W-1:0]      n_prod;
   logic                      req_accept;
   logic [SITE_W-1:0]         req_site;
   logic [COUNT_W-1:0]        site_ext;
   logic [COUNT_W-1:0]        w_ext;
   logic [COUNT_W-1:0]        sum_p1;
   logic [COUNT_W-1:0]        sum_pw;
   logic [COUNT_W-1:0]        nb_addr;
   logic [2:0]                ones_all;
   logic [2:0]                aligned;
   logic                      accept_flip;
   logic                      finish;
   logic                      out_free;
   logic                      sweep_issue;

   logic                      ram_wr_en;
   logic [SITE_W-1:0]         ram_wr_addr;
   logic                      ram_wr_data;
   logic [SITE_W-1:0]         ram_rd_addr;
   logic                      ram_rd_data;

   imsu_ram #(
      .WIDTH (1),
      .DEPTH (MAX_SITES)
   ) u_spin_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign width_wr   = csr_wr & (csr_paddr == ADDR_LATTICE_WIDTH);
   assign csr_pready = 1'b1;
   assign req_tready = (state_ff == ST_IDLE) & ~recount_pend_ff & ~width_wr;
   assign req_accept = req_tvalid & req_tready;
   assign req_site   = req_tdata[SITE_W-1:0];
   assign out_free   = ~rsp_tvalid_ff | rsp_tready;

   always_comb begin
      unique case (csr_paddr)
         ADDR_LATTICE_WIDTH: csr_prdata = CSR_DATA_W'(width_ff);
         ADDR_THRESH_FOUR:   csr_prdata = CSR_DATA_W'(thresh4_ff);
         ADDR_THRESH_EIGHT:  csr_prdata = CSR_DATA_W'(thresh8_ff);
         default:            csr_prdata = '0;
      endcase
   end

   // Lattice side in use and its site count, taken at the register write.
   always_comb begin
      w_raw = csr_pwdata[WIDTH_W-1:0];
      if (w_raw < WIDTH_W'(2)) begin
         w_sat = WIDTH_W'(2);
      end else if (w_raw > WIDTH_W'(MAX_WIDTH)) begin
         w_sat = WIDTH_W'(MAX_WIDTH);
      end else begin
         w_sat = w_raw;
      end
      n_prod = (2*WIDTH_W)'(w_sat) * (2*WIDTH_W)'(w_sat);
   end

   // Helical neighbor addresses, each reduced modulo the site count.
   always_comb begin
      site_ext = COUNT_W'(site_ff);
      w_ext    = COUNT_W'(used_w_ff);
      sum_p1   = site_ext + COUNT_W'(1);
      sum_pw   = site_ext + w_ext;
      unique case (phase_ff)
         3'd1: begin
            nb_addr = (sum_p1 == used_n_ff) ? '0 : sum_p1;
         end
         3'd2: begin
            nb_addr = (site_ext == '0) ? used_n_ff - COUNT_W'(1)
                                       : site_ext - COUNT_W'(1);
         end
         3'd3: begin
            nb_addr = (sum_pw >= used_n_ff) ? sum_pw - used_n_ff : sum_pw;
         end
         default: begin
            nb_addr = (site_ext >= w_ext) ? site_ext - w_ext
                                          : site_ext + used_n_ff - w_ext;
         end
      endcase
   end

   always_comb begin
      state_in        = state_ff;
      sweep_in        = sweep_ff;
      rc_valid_in     = 1'b0;
      recount_pend_in = recount_pend_ff;
      width_in        = width_ff;
      thresh4_in      = thresh4_ff;
      thresh8_in      = thresh8_ff;
      used_w_in       = used_w_ff;
      used_n_in       = used_n_ff;
      mag_in          = mag_ff;
      site_in         = site_ff;
      rnd_in          = rnd_ff;
      fill_spin_in    = fill_spin_ff;
      phase_in        = phase_ff;
      spin_in         = spin_ff;
      ones_in         = ones_ff;
      res_err_in      = res_err_ff;
      res_flip_in     = res_flip_ff;
      res_spin_in     = res_spin_ff;
      res_de_in       = res_de_ff;
      rsp_tvalid_in   = rsp_tvalid_ff & ~rsp_tready;
      rsp_tdata_in    = rsp_tdata_ff;
      rsp_tuser_in    = rsp_tuser_ff;
      finish          = 1'b0;
      sweep_issue     = 1'b0;
      ones_all        = ones_ff + 3'(ram_rd_data);
      aligned         = spin_ff ? ones_all : 3'd4 - ones_all;
      accept_flip     = 1'b0;
      ram_wr_en       = 1'b0;
      ram_wr_addr     = sweep_ff[SITE_W-1:0];
      ram_wr_data     = 1'b1;
      ram_rd_addr     = req_site;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en = 1'b1;
            if (sweep_ff == COUNT_W'(MAX_SITES - 1)) begin
               sweep_in = '0;
               state_in = ST_IDLE;
            end else begin
               sweep_in = sweep_ff + COUNT_W'(1);
            end
         end

         ST_RECOUNT: begin
            sweep_issue = sweep_ff < used_n_ff;
            ram_rd_addr = sweep_ff[SITE_W-1:0];
            rc_valid_in = sweep_issue;
            if (sweep_issue) begin
               sweep_in = sweep_ff + COUNT_W'(1);
            end
            if (rc_valid_ff) begin
               mag_in = ram_rd_data ? mag_ff + MAG_ONE : mag_ff - MAG_ONE;
            end
            if (!sweep_issue && !rc_valid_ff) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (recount_pend_ff) begin
               recount_pend_in = 1'b0;
               sweep_in        = '0;
               mag_in          = '0;
               state_in        = ST_RECOUNT;
            end else if (req_accept) begin
               site_in      = req_site;
               rnd_in       = req_tdata[REQ_RND_LSB +: RANDOM_BITS];
               fill_spin_in = req_tdata[REQ_FILL_BIT];
               if (req_tuser == OP_FILL) begin
                  sweep_in = '0;
                  state_in = ST_FILL;
               end else if (COUNT_W'(req_site) >= used_n_ff) begin
                  res_err_in  = 1'b1;
                  res_flip_in = 1'b0;
                  res_spin_in = 1'b0;
                  res_de_in   = '0;
                  finish      = 1'b1;
               end else begin
                  // The site itself is read in this cycle.
                  phase_in = 3'd1;
                  ones_in  = '0;
                  state_in = ST_READ;
               end
            end
         end

         ST_READ: begin
            ram_rd_addr = nb_addr[SITE_W-1:0];
            if (phase_ff == 3'd1) begin
               spin_in = ram_rd_data;
            end else begin
               ones_in = ones_ff + 3'(ram_rd_data);
            end
            phase_in = phase_ff + 3'd1;
            if (phase_ff == 3'd4) begin
               state_in = ST_DECIDE;
            end
         end

         ST_DECIDE: begin
            // aligned counts neighbors equal to the site's spin, dE = 4*aligned - 8.
            priority if (aligned <= 3'd2) begin
               accept_flip = 1'b1;
            end else if (aligned == 3'd3) begin
               accept_flip = THRESH_W'(rnd_ff) < thresh4_ff;
            end else begin
               accept_flip = THRESH_W'(rnd_ff) < thresh8_ff;
            end
            ram_wr_en   = accept_flip;
            ram_wr_addr = site_ff;
            ram_wr_data = ~spin_ff;
            if (accept_flip) begin
               mag_in = spin_ff ? mag_ff - MAG_TWO : mag_ff + MAG_TWO;
            end
            res_err_in  = 1'b0;
            res_flip_in = accept_flip;
            res_spin_in = spin_ff ^ accept_flip;
            res_de_in   = {aligned, 2'b00} - DE_W'(8);
            finish      = 1'b1;
         end

         ST_FILL: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = fill_spin_ff;
            if (sweep_ff == used_n_ff - COUNT_W'(1)) begin
               sweep_in    = used_n_ff;
               mag_in      = fill_spin_ff ? MAG_W'(used_n_ff) : -MAG_W'(used_n_ff);
               res_err_in  = 1'b0;
               res_flip_in = 1'b0;
               res_spin_in = fill_spin_ff;
               res_de_in   = '0;
               finish      = 1'b1;
            end else begin
               sweep_in = sweep_ff + COUNT_W'(1);
            end
         end

         ST_DONE: begin
            finish = 1'b1;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (finish) begin
         if (out_free) begin
            rsp_tvalid_in = 1'b1;
            rsp_tuser_in  = res_err_in;
            rsp_tdata_in  = RSP_TDATA_W'({mag_in, res_de_in, res_spin_in, res_flip_in});
            state_in      = ST_IDLE;
         end else begin
            state_in = ST_DONE;
         end
      end

      if (width_wr) begin
         width_in  = csr_pwdata[WIDTH_W-1:0];
         used_w_in = w_sat;
         used_n_in = (n_prod > (2*WIDTH_W)'(MAX_SITES)) ? COUNT_W'(MAX_SITES)
                                                        : COUNT_W'(n_prod);
         if (state_ff == ST_RECOUNT) begin
            // A new width restarts the count from the first site.
            state_in    = ST_RECOUNT;
            sweep_in    = '0;
            mag_in      = '0;
            rc_valid_in = 1'b0;
         end else begin
            recount_pend_in = 1'b1;
         end
      end
      if (csr_wr && csr_paddr == ADDR_THRESH_FOUR) begin
         thresh4_in = csr_pwdata[THRESH_W-1:0];
      end
      if (csr_wr && csr_paddr == ADDR_THRESH_EIGHT) begin
         thresh8_in = csr_pwdata[THRESH_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      site_ff      <= site_in;
      rnd_ff       <= rnd_in;
      fill_spin_ff <= fill_spin_in;
      spin_ff      <= spin_in;
      ones_ff      <= ones_in;
      res_err_ff   <= res_err_in;
      res_flip_ff  <= res_flip_in;
      res_spin_ff  <= res_spin_in;
      res_de_ff    <= res_de_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
      if (reset) begin
         state_ff        <= ST_CLEAR;
         sweep_ff        <= '0;
         rc_valid_ff     <= 1'b0;
         recount_pend_ff <= 1'b0;
         width_ff        <= WIDTH_W'(MAX_WIDTH);
         thresh4_ff      <= '0;
         thresh8_ff      <= '0;
         used_w_ff       <= WIDTH_W'(MAX_WIDTH);
         used_n_ff       <= COUNT_W'(MAX_SITES);
         mag_ff          <= MAG_W'(MAX_SITES);
         phase_ff        <= '0;
         rsp_tvalid_ff   <= 1'b0;
      end else begin
         state_ff        <= state_in;
         sweep_ff        <= sweep_in;
         rc_valid_ff     <= rc_valid_in;
         recount_pend_ff <= recount_pend_in;
         width_ff        <= width_in;
         thresh4_ff      <= thresh4_in;
         thresh8_ff      <= thresh8_in;
         used_w_ff       <= used_w_in;
         used_n_ff       <= used_n_in;
         mag_ff          <= mag_in;
         phase_ff        <= phase_in;
         rsp_tvalid_ff   <= rsp_tvalid_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

>>> hw/rtl/imsu_checker.sv
// ----------------------------------------------------------------------------
// Ising Metropolis spin update: port checker
// Watches the stream ports of the spin update block over time.
// ----------------------------------------------------------------------------
module imsu_checker
   import imsu_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   req_tuser,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic                   rsp_tuser
);

   // A stalled result holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // Reset starts the clearing pass: no item taken, no result shown.
   assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("block active right after reset");

   // An out-of-range site reports no flip, spin -1 and no energy change.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         rsp_tdata[RSP_FLIP_BIT] == 1'b0 && rsp_tdata[RSP_SPIN_BIT] == 1'b0 &&
         rsp_tdata[RSP_DE_LSB +: DE_W] == '0)
      else $error("site error result carries a change");

   // A fill sweeps the lattice, so no item follows in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == OP_FILL |=> !req_tready)
      else $error("item taken during a fill");

endmodule

bind ising_metropolis_spin_update imsu_checker u_imsu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
